// ===== src/bfti_pkg.sv =====
// ----------------------------------------------------------------------------
// bfti_pkg
// Codes, widths and types shared by the box face tile indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfti_pkg;

  // Stream payload widths; the tdata widths are padded to whole bytes
  localparam int InDataW  = 56;
  localparam int InUserW  = 1;
  localparam int OutDataW = 56;
  localparam int OutUserW = 3;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgSizeX    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeY    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeZ    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBaseTile = 2'd3;

  // Request opcodes
  localparam logic OpToIndex = 1'b0;
  localparam logic OpToTile  = 1'b1;

  // Number of faces on the box
  localparam int NumFaces = 6;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StOffFace  = 3'd1,
    StBelow    = 3'd2,
    StPastLast = 3'd3,
    StBadFace  = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ===== src/box_face_tile_index.sv =====
// ----------------------------------------------------------------------------
// box_face_tile_index
// Pipelined mapping between box face tiles and flat tile numbers.
// ----------------------------------------------------------------------------
// One request per cycle unless stalled, one result per request, in order.
// Opcode OpToIndex turns a face, column and row into a flat tile number:
// base_tile plus the tile counts of all earlier faces plus row * width + col.
// Faces 0 and 1 are size_z wide and size_y high, faces 2 and 3 size_x wide
// and size_z high, faces 4 and 5 size_x wide and size_y high. A coordinate
// off the face returns the face's first tile with status off-face; face 6 or
// 7 returns zero with status bad-face. Opcode OpToTile finds the face holding
// a tile number by comparing against running face totals, then splits the
// offset into row and column with a restoring divider of one quotient bit
// per stage. Numbers below base_tile or past face 5 are flagged and return
// zeros. From request accept to result valid a request passes an input
// register, three arithmetic stages, one divider stage per quotient bit and
// the output register. Every stage has its own valid bit and moves when
// the next one is empty or moving, so a stalled output holds only what is
// needed and bubbles close up. Write the configuration only while no
// request is in flight; cfg_ready_o is always high. Flat numbers wrap
// modulo 2^INDEX_BITS (at most 32 bits).
// ----------------------------------------------------------------------------
`default_nettype none

module box_face_tile_index #(
  parameter int DIM_BITS   = 8,
  parameter int INDEX_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: face[2:0], col[12:3], row[22:13], tile_number[54:23], zero[55]
  input  logic [bfti_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: opcode[0]
  input  logic [bfti_pkg::InUserW-1:0]   s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: result_index[31:0], result_face[34:32], result_col[42:35],
  //        result_row[50:43], zero[55:51]
  output logic [bfti_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: status[2:0]
  output logic [bfti_pkg::OutUserW-1:0]  m_axis_tuser,
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfti_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bfti_pkg::CfgDataW-1:0]  cfg_data_i
);

  import bfti_pkg::*;

  // Dimension registers are DW bits wide: DIM_BITS, capped at 8.
  localparam int DW = (DIM_BITS < 8) ? DIM_BITS : 8;
  localparam int PW = 2 * DW;            // one face's tile count
  localparam int CW = PW + 3;            // running total over six faces
  localparam int IW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam logic [31:0] IdxMask = 32'((64'd1 << IW) - 64'd1);

  typedef struct packed {
    logic        op;
    logic [2:0]  face;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [31:0] tn;
  } s0_t;

  typedef struct packed {
    logic          op;
    logic          bad;
    logic [2:0]    face;
    logic          oob;
    logic [DW-1:0] w;
    logic [DW-1:0] rowc;
    logic [DW-1:0] colc;
    logic [PW-1:0] pzy;
    logic [PW-1:0] pxz;
    logic [PW-1:0] pxy;
    logic          below;
    logic [31:0]   loc;
  } s1_t;

  typedef struct packed {
    logic                          op;
    logic                          bad;
    logic [2:0]                    face;
    logic                          oob;
    logic [DW-1:0]                 colc;
    logic [PW-1:0]                 rw;
    logic [NumFaces-1:0][CW-1:0]   cum;
    logic                          below;
    logic [31:0]                   loc;
  } s2_t;

  typedef struct packed {
    logic          op;
    logic [31:0]   idx;
    logic [2:0]    face;
    status_e       status;
    logic [DW-1:0] rem;
    logic [DW-1:0] num;
    logic [DW-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic [31:0] idx;
    logic [2:0]  face;
    logic [7:0]  col;
    logic [7:0]  row;
    status_e     status;
  } out_t;

  // One restoring division step: bring down the next dividend bit, shift in
  // one quotient bit.
  function automatic div_t div_step(div_t a);
    div_t        res;
    logic [DW:0] t;
    logic        q;
    res = a;
    t   = {a.rem, a.num[DW-1]};
    q   = (t >= {1'b0, a.dvs});
    if (q) begin
      res.rem = DW'(t - {1'b0, a.dvs});
    end else begin
      res.rem = t[DW-1:0];
    end
    res.num = {a.num[DW-2:0], q};
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0] sx_q, sy_q, sz_q;
  logic [31:0]   base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= DW'(1);
      sy_q   <= DW'(1);
      sz_q   <= DW'(1);
      base_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSizeX:    sx_q   <= cfg_data_i[DW-1:0];
        CfgSizeY:    sy_q   <= cfg_data_i[DW-1:0];
        CfgSizeZ:    sz_q   <= cfg_data_i[DW-1:0];
        CfgBaseTile: base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage advances when it is empty or its
  // successor advances.
  // --------------------------------------------------------------------------
  logic          s0_v_q, s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic [DW-1:0] dv_v_q;
  logic          en_s0, en_s1, en_s2, en_s3, en_out;
  logic [DW-1:0] en_dv;

  always_comb begin
    en_out        = !out_v_q || m_axis_tready;
    en_dv[DW-1]   = !dv_v_q[DW-1] || en_out;
    for (int k = DW - 2; k >= 0; k--) begin
      en_dv[k] = !dv_v_q[k] || en_dv[k+1];
    end
    en_s3 = !s3_v_q || en_dv[0];
    en_s2 = !s2_v_q || en_s3;
    en_s1 = !s1_v_q || en_s2;
    en_s0 = !s0_v_q || en_s1;
  end

  assign s_axis_tready = en_s0;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en_s0) s0_v_q <= s_axis_tvalid;
      if (en_s1) s1_v_q <= s0_v_q;
      if (en_s2) s2_v_q <= s1_v_q;
      if (en_s3) s3_v_q <= s2_v_q;
      if (en_dv[0]) dv_v_q[0] <= s3_v_q;
      for (int k = 1; k < DW; k++) begin
        if (en_dv[k]) dv_v_q[k] <= dv_v_q[k-1];
      end
      if (en_out) out_v_q <= dv_v_q[DW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: face geometry, bounds check, face tile counts, offset from base
  // --------------------------------------------------------------------------
  s0_t s0_q;
  s1_t s1_q, s1_d;

  always_comb begin
    logic [DW-1:0] w1, h1;
    w1 = (s0_q.face < 3'd2) ? sz_q : sx_q;
    h1 = (s0_q.face < 3'd2) ? sy_q : ((s0_q.face < 3'd4) ? sz_q : sy_q);
    s1_d.op    = s0_q.op;
    s1_d.bad   = (s0_q.face >= 3'(NumFaces));
    s1_d.face  = s0_q.face;
    // a negative coordinate has its sign bit set, so the unsigned compares
    // only decide for non-negative values
    s1_d.oob   = s0_q.col[9] || s0_q.row[9] ||
                 (s0_q.col >= 10'(w1)) || (s0_q.row >= 10'(h1));
    s1_d.w     = w1;
    s1_d.rowc  = s0_q.row[DW-1:0];
    s1_d.colc  = s0_q.col[DW-1:0];
    s1_d.pzy   = PW'(sz_q) * PW'(sy_q);
    s1_d.pxz   = PW'(sx_q) * PW'(sz_q);
    s1_d.pxy   = PW'(sx_q) * PW'(sy_q);
    s1_d.below = (s0_q.tn < base_q);
    s1_d.loc   = s0_q.tn - base_q;
  end

  // --------------------------------------------------------------------------
  // Stage 2: running face totals, row times width
  // --------------------------------------------------------------------------
  s2_t s2_q, s2_d;

  always_comb begin
    logic [CW-1:0] c3;
    c3 = (CW'(s1_q.pzy) << 1) + (CW'(s1_q.pxz) << 1);
    s2_d.op     = s1_q.op;
    s2_d.bad    = s1_q.bad;
    s2_d.face   = s1_q.face;
    s2_d.oob    = s1_q.oob;
    s2_d.colc   = s1_q.colc;
    s2_d.rw     = PW'(s1_q.rowc) * PW'(s1_q.w);
    s2_d.cum[0] = CW'(s1_q.pzy);
    s2_d.cum[1] = CW'(s1_q.pzy) << 1;
    s2_d.cum[2] = (CW'(s1_q.pzy) << 1) + CW'(s1_q.pxz);
    s2_d.cum[3] = c3;
    s2_d.cum[4] = c3 + CW'(s1_q.pxy);
    s2_d.cum[5] = c3 + (CW'(s1_q.pxy) << 1);
    s2_d.below  = s1_q.below;
    s2_d.loc    = s1_q.loc;
  end

  // --------------------------------------------------------------------------
  // Stage 3: flat number for OpToIndex; face search and offset for OpToTile
  // --------------------------------------------------------------------------
  div_t s3_q, s3_d;

  always_comb begin
    logic [CW-1:0] pre, prev;
    logic [31:0]   sum;
    logic          found;
    logic [2:0]    fsel;
    logic [PW-1:0] off;
    pre = '0;
    for (int f = 1; f < NumFaces; f++) begin
      if (s2_q.face == 3'(f)) pre = s2_q.cum[f-1];
    end
    sum = base_q + 32'(pre) +
          (s2_q.oob ? 32'd0 : (32'(s2_q.rw) + 32'(s2_q.colc)));

    // first face whose running total passes the offset; empty faces drop out
    found = 1'b0;
    fsel  = '0;
    off   = '0;
    prev  = '0;
    for (int f = 0; f < NumFaces; f++) begin
      if (!found && (s2_q.loc < 32'(s2_q.cum[f]))) begin
        found = 1'b1;
        fsel  = 3'(f);
        off   = PW'(s2_q.loc - 32'(prev));
      end
      prev = s2_q.cum[f];
    end

    s3_d.op   = s2_q.op;
    s3_d.face = fsel;
    s3_d.rem  = off[PW-1:DW];
    s3_d.num  = off[DW-1:0];
    s3_d.dvs  = (fsel < 3'd2) ? sz_q : sx_q;
    if (s2_q.op == OpToIndex) begin
      s3_d.idx = s2_q.bad ? 32'd0 : (sum & IdxMask);
      if (s2_q.bad) begin
        s3_d.status = StBadFace;
      end else if (s2_q.oob) begin
        s3_d.status = StOffFace;
      end else begin
        s3_d.status = StOk;
      end
    end else begin
      s3_d.idx = 32'd0;
      if (s2_q.below) begin
        s3_d.status = StBelow;
      end else if (!found) begin
        s3_d.status = StPastLast;
      end else begin
        s3_d.status = StOk;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: one quotient bit each, row in num, column in rem
  // --------------------------------------------------------------------------
  div_t dv_q [DW];

  // --------------------------------------------------------------------------
  // Output formatting: zero the fields that do not apply
  // --------------------------------------------------------------------------
  out_t out_q, out_d;

  always_comb begin
    out_d.idx    = dv_q[DW-1].idx;
    out_d.status = dv_q[DW-1].status;
    if ((dv_q[DW-1].op == OpToTile) && (dv_q[DW-1].status == StOk)) begin
      out_d.face = dv_q[DW-1].face;
      out_d.col  = 8'(dv_q[DW-1].rem);
      out_d.row  = 8'(dv_q[DW-1].num);
    end else begin
      out_d.face = '0;
      out_d.col  = '0;
      out_d.row  = '0;
    end
  end

  // Payload registers: load on advance with a valid request upstream
  always_ff @(posedge clk_i) begin
    if (en_s0 && s_axis_tvalid) begin
      s0_q.op   <= s_axis_tuser[0];
      s0_q.face <= s_axis_tdata[2:0];
      s0_q.col  <= s_axis_tdata[12:3];
      s0_q.row  <= s_axis_tdata[22:13];
      s0_q.tn   <= s_axis_tdata[54:23];
    end
    if (en_s1 && s0_v_q) s1_q <= s1_d;
    if (en_s2 && s1_v_q) s2_q <= s2_d;
    if (en_s3 && s2_v_q) s3_q <= s3_d;
    if (en_dv[0] && s3_v_q) dv_q[0] <= div_step(s3_q);
    for (int k = 1; k < DW; k++) begin
      if (en_dv[k] && dv_v_q[k-1]) dv_q[k] <= div_step(dv_q[k-1]);
    end
    if (en_out && dv_v_q[DW-1]) out_q <= out_d;
  end

  assign m_axis_tdata = {5'd0, out_q.row, out_q.col, out_q.face, out_q.idx};
  assign m_axis_tuser = out_q.status;

endmodule

`default_nettype wire

// ===== test/box_face_tile_index_tb.sv =====
// ----------------------------------------------------------------------------
// box_face_tile_index_tb
// Self-checking bench for the box face tile indexer.
// ----------------------------------------------------------------------------
// Streams face/coordinate lookups and tile number lookups into the block
// under a series of box sizes and base tiles, predicts every result in the
// bench and compares the results in order, field by field. Both stream sides
// stall at random, one phase runs with no gaps, and one phase holds off the
// result side long enough for the pipeline to back up into the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module box_face_tile_index_tb;

  import bfti_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainWait  = 20;   // pipeline is DIM_BITS + 5 stages deep

  // One request as the bench sees it
  typedef struct packed {
    logic        opcode;
    logic [2:0]  face;
    logic [9:0]  col;           // two's complement
    logic [9:0]  row;           // two's complement
    logic [31:0] tile_number;
  } tile_req_t;

  // One result as the bench sees it
  typedef struct packed {
    logic [31:0] index;
    logic [2:0]  face;
    logic [7:0]  col;
    logic [7:0]  row;
    status_e     status;
  } tile_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Bench copy of the configuration, updated when a write is accepted
  logic [7:0]  box_x    = 8'd1;
  logic [7:0]  box_y    = 8'd1;
  logic [7:0]  box_z    = 8'd1;
  logic [31:0] box_base = 32'd0;

  tile_req_t   tile_requests[$];   // requests not yet offered
  tile_res_t   mapped_due[$];      // predicted results, oldest first
  tile_req_t   offered_req;
  tile_res_t   seen_res;
  tile_res_t   want_res;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_given = 0;
  int unsigned hold_left   = 0;
  logic        no_gaps     = 1'b0;

  box_face_tile_index i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Faces 0/1 are z by y, faces 2/3 x by z, faces 4/5 x by y
  function automatic longint unsigned face_w(int f);
    return (f < 2) ? longint'(box_z) : longint'(box_x);
  endfunction

  function automatic longint unsigned face_h(int f);
    if (f < 2) return longint'(box_y);
    if (f < 4) return longint'(box_z);
    return longint'(box_y);
  endfunction

  function automatic tile_res_t map_tile(tile_req_t rq);
    tile_res_t         res;
    longint unsigned   acc;
    longint unsigned   offset;
    longint unsigned   w;
    longint unsigned   cnt;
    logic              found;
    res        = '0;
    res.status = StOk;
    if (rq.opcode == OpToIndex) begin
      if (int'(rq.face) >= NumFaces) begin
        res.status = StBadFace;
      end else begin
        // Start from the first tile of the requested face
        acc = longint'(box_base);
        for (int f = 0; f < int'(rq.face); f++) acc += face_w(f) * face_h(f);
        w = face_w(int'(rq.face));
        // A set sign bit means a negative coordinate, which is off the face
        if (rq.col[9] || rq.row[9] || rq.col >= w || rq.row >= face_h(int'(rq.face))) begin
          res.status = StOffFace;
        end else begin
          acc += longint'(rq.row) * w + longint'(rq.col);
        end
        res.index = acc[31:0];
      end
    end else if (rq.tile_number < box_base) begin
      res.status = StBelow;
    end else begin
      // Walk the faces, peeling off each face's tile count; empty faces never match
      offset = longint'(rq.tile_number - box_base);
      found  = 1'b0;
      for (int f = 0; f < NumFaces; f++) begin
        if (!found) begin
          w   = face_w(f);
          cnt = w * face_h(f);
          if (offset < cnt) begin
            found    = 1'b1;
            res.face = 3'(f);
            res.col  = 8'(offset % w);
            res.row  = 8'(offset / w);
          end else begin
            offset -= cnt;
          end
        end
      end
      if (!found) res.status = StPastLast;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void push_req(logic op, int face, int col, int row, logic [31:0] tn);
    tile_req_t rq;
    rq.opcode      = op;
    rq.face        = 3'(face);
    rq.col         = 10'(col);
    rq.row         = 10'(row);
    rq.tile_number = tn;
    tile_requests.push_back(rq);
  endfunction

  // Mostly well-formed lookups that land on the box, with edges and noise mixed in
  function automatic tile_req_t make_random_req();
    tile_req_t       rq;
    longint unsigned w;
    longint unsigned h;
    longint unsigned total;
    int              pick;
    rq.opcode      = 1'($urandom_range(1));
    rq.face        = 3'($urandom);
    rq.col         = 10'($urandom);
    rq.row         = 10'($urandom);
    rq.tile_number = $urandom;
    pick           = $urandom_range(99);
    if (rq.opcode == OpToIndex) begin
      if (pick < 90) rq.face = 3'($urandom_range(NumFaces - 1));
      w = face_w(int'(rq.face));
      h = face_h(int'(rq.face));
      if (pick < 70 && w != 0 && h != 0) begin
        rq.col = 10'($urandom_range(32'(w - 1)));
        rq.row = 10'($urandom_range(32'(h - 1)));
      end else if (pick < 80) begin
        // Step just past the face edge
        rq.col = ($urandom_range(1) != 0) ? 10'(w) : 10'h3FF;
        rq.row = ($urandom_range(1) != 0) ? 10'(h) : 10'($urandom_range(32'(h)));
      end
    end else begin
      total = 0;
      for (int f = 0; f < NumFaces; f++) total += face_w(f) * face_h(f);
      if (pick < 80) rq.tile_number = box_base + $urandom_range(32'(total + 2));
      else if (pick < 90) rq.tile_number = box_base - 32'd1 - $urandom_range(3);
    end
    return rq;
  endfunction

  task automatic add_random_reqs(int n);
    for (int k = 0; k < n; k++) tile_requests.push_back(make_random_req());
  endtask

  // Write one register and mirror it once the write is accepted
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgSizeX:    box_x    = val[7:0];
      CfgSizeY:    box_y    = val[7:0];
      CfgSizeZ:    box_z    = val[7:0];
      CfgBaseTile: box_base = val;
      default: ;
    endcase
  endtask

  // Size registers only keep their low byte; drive junk above it
  task automatic set_box(logic [7:0] sx, logic [7:0] sy, logic [7:0] sz, logic [31:0] base);
    write_reg(CfgSizeX, {24'($urandom), sx});
    write_reg(CfgSizeY, {24'($urandom), sy});
    write_reg(CfgSizeZ, {24'($urandom), sz});
    write_reg(CfgBaseTile, base);
    @(negedge clk_i);
  endtask

  // Wait until every request is offered, accepted and answered
  task automatic drain();
    while (tile_requests.size() != 0 || s_axis_tvalid || mapped_due.size() != 0)
      @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: offer the next queued request, predict it on accept
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) mapped_due.push_back(map_tile(offered_req));
      // Only move on once the current request is taken; never drop a held one
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tile_requests.size() != 0 && (no_gaps || $urandom_range(99) >= 14)) begin
          offered_req   = tile_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, offered_req.tile_number, offered_req.row,
                            offered_req.col, offered_req.face};
          s_axis_tuser  <= offered_req.opcode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off of the result side, counted here on its own
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left   <= 0;
      holds_given <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_given != holds_asked) begin
      holds_given <= holds_given + 1;
      hold_left   <= HoldCycles;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_res.index  = m_axis_tdata[31:0];
        seen_res.face   = m_axis_tdata[34:32];
        seen_res.col    = m_axis_tdata[42:35];
        seen_res.row    = m_axis_tdata[50:43];
        seen_res.status = status_e'(m_axis_tuser[2:0]);
        if (mapped_due.size() == 0) begin
          $error("result with no request in flight: index %0h status %0d",
                 seen_res.index, seen_res.status);
          mismatches++;
        end else begin
          want_res = mapped_due.pop_front();
          if (seen_res.index !== want_res.index) begin
            $error("result_index: expected %0h, actual %0h", want_res.index, seen_res.index);
            mismatches++;
          end
          if (seen_res.face !== want_res.face) begin
            $error("result_face: expected %0d, actual %0d", want_res.face, seen_res.face);
            mismatches++;
          end
          if (seen_res.col !== want_res.col) begin
            $error("result_col: expected %0d, actual %0d", want_res.col, seen_res.col);
            mismatches++;
          end
          if (seen_res.row !== want_res.row) begin
            $error("result_row: expected %0d, actual %0d", want_res.row, seen_res.row);
            mismatches++;
          end
          if (seen_res.status !== want_res.status) begin
            $error("status: expected %0d, actual %0d", want_res.status, seen_res.status);
            mismatches++;
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && (no_gaps || $urandom_range(99) >= 14);
    end
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset box: six faces of one tile each, numbered from zero
    push_req(OpToIndex, 0, 0, 0, 32'd0);
    push_req(OpToTile, 0, 0, 0, 32'd5);
    push_req(OpToTile, 0, 0, 0, 32'd6);
    drain();

    // Small uneven box: faces of 8, 8, 12, 12, 6, 6 tiles from tile 100
    set_box(8'd3, 8'd2, 8'd4, 32'd100);
    for (int f = 0; f < NumFaces; f++)
      push_req(OpToIndex, f, int'(face_w(f)) - 1, int'(face_h(f)) - 1, 32'd0);
    push_req(OpToIndex, 0, 0, 0, 32'd0);
    push_req(OpToIndex, 5, 0, 0, 32'd0);
    // Bad faces
    push_req(OpToIndex, 6, 0, 0, 32'd0);
    push_req(OpToIndex, 7, 511, -512, 32'hFFFF_FFFF);
    // Off the face: negative and just past the edge
    push_req(OpToIndex, 2, -1, 0, 32'd0);
    push_req(OpToIndex, 3, 511, -512, 32'd0);
    push_req(OpToIndex, 1, 4, 0, 32'd0);
    push_req(OpToIndex, 4, 0, 2, 32'd0);
    // Below base, first and last tile, past the last face
    push_req(OpToTile, 0, 0, 0, 32'd0);
    push_req(OpToTile, 0, 0, 0, 32'd99);
    push_req(OpToTile, 0, 0, 0, 32'd100);
    push_req(OpToTile, 0, 0, 0, 32'd151);
    push_req(OpToTile, 0, 0, 0, 32'd152);
    push_req(OpToTile, 7, -1, -1, 32'hFFFF_FFFF);
    drain();

    // Random phases under a range of boxes, empty faces and wrapping bases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 1:    set_box(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                         8'($urandom_range(1, 12)), $urandom);
        2:       set_box(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
        3:       set_box(8'd0, 8'd7, 8'd3, 32'd0);
        4:       set_box(8'd4, 8'd0, 8'd5, $urandom);
        default: set_box(8'd255, 8'd1, 8'd0, 32'hFFFF_0000);
      endcase
      // Back up the pipeline once; run one phase with no gaps at all
      if (ph == 0) holds_asked = holds_asked + 1;
      no_gaps = (ph == 1);
      add_random_reqs(90);
      drain();
    end
    no_gaps = 1'b0;

    repeat (DrainWait) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== box_face_tile_index.f =====
src/bfti_pkg.sv
src/box_face_tile_index.sv
test/box_face_tile_index_tb.sv
